### design/mzvt_pkg.sv
// ----------------------------------------------------------------------------
// mzvt_pkg - shared types and codes for the multi-zone valve timer
// Command codes, the decoded command word passed from the front end to the
// back end, and the result word.
// ----------------------------------------------------------------------------
`default_nettype none

package mzvt_pkg;

    // Width of the zone mask and of the per-zone result vectors
    localparam int MASK_W = 3;

    // Raw command codes on the mode port
    localparam logic [3:0] MODE_TICK      = 4'd0;
    localparam logic [3:0] MODE_START     = 4'd1;
    localparam logic [3:0] MODE_ADD       = 4'd2;
    localparam logic [3:0] MODE_PAUSE     = 4'd3;
    localparam logic [3:0] MODE_STOP      = 4'd4;
    localparam logic [3:0] MODE_SET_OVR   = 4'd5;
    localparam logic [3:0] MODE_FLIP_OVR  = 4'd6;
    localparam logic [3:0] MODE_SLEEP     = 4'd7;
    localparam logic [3:0] MODE_DEEP      = 4'd8;
    localparam logic [3:0] MODE_WAKE      = 4'd9;
    localparam logic [3:0] MODE_HZ_SET    = 4'd10;
    localparam logic [3:0] MODE_HZ_CLR    = 4'd11;
    localparam logic [3:0] MODE_HZ_FLIP   = 4'd12;
    localparam logic [3:0] MODE_CLEAR     = 4'd13;
    localparam logic [3:0] MODE_STATUS    = 4'd14;

    // Decoded operation carried to the back end
    typedef enum logic [3:0] {
        OP_NONE,
        OP_TICK,
        OP_START,
        OP_ADD,
        OP_PAUSE,
        OP_STOP,
        OP_SET_OVR,
        OP_FLIP_OVR,
        OP_SLEEP,
        OP_DEEP,
        OP_WAKE,
        OP_HZ_SET,
        OP_HZ_CLR,
        OP_HZ_FLIP,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [MASK_W-1:0] sel;          // zone select, limited to existing zones
        logic [7:0]        dur;
        logic              ovr;
        logic [1:0]        stat_zone;
        logic              stat_valid;   // stat_zone names an existing zone
    } t_cmd;

    typedef struct packed {
        logic [MASK_W-1:0] drive;
        logic [MASK_W-1:0] ovr_mask;
        logic              hazard;
        logic              deep;
        logic [7:0]        sleep;
        logic [7:0]        spray;
        logic [7:0]        pause;
    } t_result;

endpackage

`default_nettype wire

### design/mzvt_fifo.sv
// ----------------------------------------------------------------------------
// mzvt_fifo - small register queue
// Push/full on the write side, pop/empty on the read side; head word is
// presented while not empty. Push and pop may occur in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mzvt_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + PW'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + PW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage: write at the tail only
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fifo count beyond depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_do_push && !w_do_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("fifo count did not advance on push");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0 && r_count != CW'(DEPTH)) |-> (r_wr_ptr != r_rd_ptr))
        else $error("fifo pointers collide while partly filled");

endmodule

`default_nettype wire

### design/mzvt_front.sv
// ----------------------------------------------------------------------------
// mzvt_front - command intake and decode
// Accepts words from the input channel and turns the raw mode into an
// operation, trims the zone mask and checks the status zone.
// ----------------------------------------------------------------------------
`default_nettype none

module mzvt_front
    import mzvt_pkg::*;
#(
    parameter int ZONES = 3
) (
    input  wire logic              i_push,
    output logic                   o_full,
    input  wire logic [3:0]        i_mode,
    input  wire logic [MASK_W-1:0] i_zone_mask,
    input  wire logic [7:0]        i_duration,
    input  wire logic              i_override_value,
    input  wire logic [1:0]        i_status_zone,
    input  wire logic              i_q_full,
    output logic                   o_q_push,
    output t_cmd                   o_cmd
);

    localparam int OUT_Z = (ZONES < MASK_W) ? ZONES : MASK_W;

    t_op               w_op;
    logic [MASK_W-1:0] w_sel;

    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        case (i_mode)
            MODE_TICK:     w_op = OP_TICK;
            MODE_START:    w_op = OP_START;
            MODE_ADD:      w_op = OP_ADD;
            MODE_PAUSE:    w_op = OP_PAUSE;
            MODE_STOP:     w_op = OP_STOP;
            MODE_SET_OVR:  w_op = OP_SET_OVR;
            MODE_FLIP_OVR: w_op = OP_FLIP_OVR;
            MODE_SLEEP:    w_op = OP_SLEEP;
            MODE_DEEP:     w_op = OP_DEEP;
            MODE_WAKE:     w_op = OP_WAKE;
            MODE_HZ_SET:   w_op = OP_HZ_SET;
            MODE_HZ_CLR:   w_op = OP_HZ_CLR;
            MODE_HZ_FLIP:  w_op = OP_HZ_FLIP;
            MODE_CLEAR:    w_op = OP_CLEAR;
            MODE_STATUS:   w_op = OP_NONE;
            default:       w_op = OP_NONE;
        endcase
    end

    // Drop mask bits for zones that do not exist
    always_comb begin
        w_sel = '0;
        for (int z = 0; z < OUT_Z; z++) begin
            w_sel[z] = i_zone_mask[z];
        end
    end

    always_comb begin
        o_cmd            = '0;
        o_cmd.op         = w_op;
        o_cmd.sel        = w_sel;
        o_cmd.dur        = i_duration;
        o_cmd.ovr        = i_override_value;
        o_cmd.stat_zone  = i_status_zone;
        o_cmd.stat_valid = (int'(i_status_zone) < ZONES);
    end

endmodule

`default_nettype wire

### design/mzvt_back.sv
// ----------------------------------------------------------------------------
// mzvt_back - zone state and command execution
// Holds per-zone counters and flags, applies one decoded command a cycle while
// the result queue has room, and forms the status word from the updated state.
// ----------------------------------------------------------------------------
`default_nettype none

module mzvt_back
    import mzvt_pkg::*;
#(
    parameter int ZONES = 3
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_empty,
    input  wire t_cmd i_cmd,
    output logic      o_cmd_pop,
    input  wire logic i_res_full,
    output logic      o_res_push,
    output t_result   o_res
);

    localparam int OUT_Z = (ZONES < MASK_W) ? ZONES : MASK_W;

    logic [7:0]        r_spray [ZONES];
    logic [7:0]        n_spray [ZONES];
    logic [7:0]        r_pause [ZONES];
    logic [7:0]        n_pause [ZONES];
    logic              r_ovr   [ZONES];
    logic              n_ovr   [ZONES];
    logic [7:0]        r_sleep, n_sleep;
    logic              r_deep, n_deep;
    logic              r_hazard, n_hazard;
    logic [MASK_W-1:0] r_drive, n_drive;
    logic [7:0]        w_sleep_dec;
    logic              w_fire;

    assign w_fire      = !i_cmd_empty && !i_res_full;
    assign o_cmd_pop   = w_fire;
    assign o_res_push  = w_fire;
    assign w_sleep_dec = (r_sleep != 8'd0) ? r_sleep - 8'd1 : r_sleep;

    always_comb begin
        n_spray  = r_spray;
        n_pause  = r_pause;
        n_ovr    = r_ovr;
        n_sleep  = r_sleep;
        n_deep   = r_deep;
        n_hazard = r_hazard;
        n_drive  = r_drive;
        if (w_fire) begin
            case (i_cmd.op)
                OP_TICK: begin
                    n_sleep = w_sleep_dec;
                    for (int z = 0; z < ZONES; z++) begin
                        if (r_spray[z] != 8'd0) n_spray[z] = r_spray[z] - 8'd1;
                        if (r_pause[z] != 8'd0) n_pause[z] = r_pause[z] - 8'd1;
                    end
                    n_drive = '0;
                    for (int z = 0; z < OUT_Z; z++) begin
                        n_drive[z] = !r_hazard && (r_ovr[z] ||
                            (n_spray[z] != 8'd0 && n_pause[z] == 8'd0 &&
                             w_sleep_dec == 8'd0 && !r_deep));
                    end
                end
                OP_START: begin
                    for (int z = 0; z < OUT_Z; z++)
                        if (i_cmd.sel[z]) n_spray[z] = i_cmd.dur;
                end
                OP_ADD: begin
                    for (int z = 0; z < OUT_Z; z++)
                        if (i_cmd.sel[z]) n_spray[z] = r_spray[z] + i_cmd.dur;
                end
                OP_PAUSE: begin
                    for (int z = 0; z < OUT_Z; z++)
                        if (i_cmd.sel[z]) n_pause[z] = i_cmd.dur;
                end
                OP_STOP: begin
                    for (int z = 0; z < OUT_Z; z++)
                        if (i_cmd.sel[z]) n_spray[z] = 8'd0;
                end
                OP_SET_OVR: begin
                    for (int z = 0; z < OUT_Z; z++)
                        if (i_cmd.sel[z]) n_ovr[z] = i_cmd.ovr;
                end
                OP_FLIP_OVR: begin
                    // every selected zone takes the inverse of zone 0's old bit
                    for (int z = 0; z < OUT_Z; z++)
                        if (i_cmd.sel[z]) n_ovr[z] = !r_ovr[0];
                end
                OP_SLEEP:   n_sleep = i_cmd.dur;
                OP_DEEP:    n_deep = 1'b1;
                OP_WAKE: begin
                    n_sleep = 8'd0;
                    n_deep  = 1'b0;
                end
                OP_HZ_SET:  n_hazard = 1'b1;
                OP_HZ_CLR:  n_hazard = 1'b0;
                OP_HZ_FLIP: n_hazard = !r_hazard;
                OP_CLEAR: begin
                    for (int z = 0; z < ZONES; z++) begin
                        n_spray[z] = 8'd0;
                        n_pause[z] = 8'd0;
                        n_ovr[z]   = 1'b0;
                    end
                    n_deep   = 1'b0;
                    n_hazard = 1'b0;
                end
                default: ;
            endcase
        end
    end

    // Status word from the state after this command
    always_comb begin
        o_res        = '0;
        o_res.drive  = n_drive;
        o_res.hazard = n_hazard;
        o_res.deep   = n_deep;
        o_res.sleep  = n_sleep;
        for (int z = 0; z < OUT_Z; z++) begin
            o_res.ovr_mask[z] = n_ovr[z];
        end
        for (int z = 0; z < ZONES; z++) begin
            if (i_cmd.stat_valid && int'(i_cmd.stat_zone) == z) begin
                o_res.spray = n_spray[z];
                o_res.pause = n_pause[z];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int z = 0; z < ZONES; z++) begin
                r_spray[z] <= 8'd0;
                r_pause[z] <= 8'd0;
                r_ovr[z]   <= 1'b0;
            end
            r_sleep  <= 8'd0;
            r_deep   <= 1'b0;
            r_hazard <= 1'b0;
            r_drive  <= '0;
        end else begin
            r_spray  <= n_spray;
            r_pause  <= n_pause;
            r_ovr    <= n_ovr;
            r_sleep  <= n_sleep;
            r_deep   <= n_deep;
            r_hazard <= n_hazard;
            r_drive  <= n_drive;
        end
    end

    a_hazard_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_cmd.op == OP_TICK && r_hazard) |=> (r_drive == '0))
        else $error("drive on after tick under hazard");

    a_drive_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_fire && i_cmd.op == OP_TICK) |=> $stable(r_drive))
        else $error("drive changed without a tick");

    a_clear_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_cmd.op == OP_CLEAR) |=> (!r_hazard && !r_deep))
        else $error("clear left hazard or deep sleep set");

endmodule

`default_nettype wire

### design/multi_zone_valve_timer.sv
// ----------------------------------------------------------------------------
// multi_zone_valve_timer - irrigation valve controller for several zones
// Per-zone spray and pause countdowns with manual override, global sleep,
// deep sleep and hazard; drive bits are recomputed on each tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: present a command word on i_mode and its fields, raise
//   push; the word is taken on a clock edge with push high and full low.
//   Result channel: while empty is low the status word for the oldest
//   command sits on the o_ ports; raise pop to take it.
//   Every command gives exactly one status word, reflecting the state after
//   that command. Drive bits change on tick commands only.
//   A taken word is registered in the command queue, then the back end applies
//   it and writes its status word into the result queue.
//   Throughput: one word per cycle while pop keeps the result queue from
//   filling, set by the back end updating the zone registers for each word.
//   Stall: when pop stays low the two-entry result queue fills, the back
//   end holds, then the two-entry command queue fills and full rises.
//   Reset (i_rst_n low, synchronous): clears all counters, flags, drive
//   bits and both queues.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_zone_valve_timer
    import mzvt_pkg::*;
#(
    parameter int ZONES = 3
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // command channel
    input  wire logic              push,
    output logic                   full,
    input  wire logic [3:0]        i_mode,
    input  wire logic [MASK_W-1:0] i_zone_mask,
    input  wire logic [7:0]        i_duration,
    input  wire logic              i_override_value,
    input  wire logic [1:0]        i_status_zone,
    // status channel
    output logic                   empty,
    input  wire logic              pop,
    output logic [MASK_W-1:0]      o_zone_drive,
    output logic [MASK_W-1:0]      o_override_mask,
    output logic                   o_hazard_active,
    output logic                   o_deep_asleep,
    output logic [7:0]             o_sleep_left,
    output logic [7:0]             o_spray_left,
    output logic [7:0]             o_pause_left
);

    localparam int QDEPTH = 2;

    t_cmd    w_cmd_in, w_cmd_out;
    t_result w_res_in, w_res_out;
    logic    w_cq_push, w_cq_full, w_cq_pop, w_cq_empty;
    logic    w_rq_push, w_rq_full;

    // Front end: take words and decode them
    mzvt_front #(.ZONES(ZONES)) u_front (
        .i_push           (push),
        .o_full           (full),
        .i_mode           (i_mode),
        .i_zone_mask      (i_zone_mask),
        .i_duration       (i_duration),
        .i_override_value (i_override_value),
        .i_status_zone    (i_status_zone),
        .i_q_full         (w_cq_full),
        .o_q_push         (w_cq_push),
        .o_cmd            (w_cmd_in)
    );

    // Decoded command queue between front and back
    mzvt_fifo #(.WIDTH($bits(t_cmd)), .DEPTH(QDEPTH)) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_cq_push),
        .i_data  (w_cmd_in),
        .o_full  (w_cq_full),
        .i_pop   (w_cq_pop),
        .o_data  (w_cmd_out),
        .o_empty (w_cq_empty)
    );

    // Back end: advance counters and flags, build the status word
    mzvt_back #(.ZONES(ZONES)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (w_cq_empty),
        .i_cmd       (w_cmd_out),
        .o_cmd_pop   (w_cq_pop),
        .i_res_full  (w_rq_full),
        .o_res_push  (w_rq_push),
        .o_res       (w_res_in)
    );

    // Result queue: hold status words while the receiver stalls
    mzvt_fifo #(.WIDTH($bits(t_result)), .DEPTH(QDEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_rq_push),
        .i_data  (w_res_in),
        .o_full  (w_rq_full),
        .i_pop   (pop),
        .o_data  (w_res_out),
        .o_empty (empty)
    );

    assign o_zone_drive    = w_res_out.drive;
    assign o_override_mask = w_res_out.ovr_mask;
    assign o_hazard_active = w_res_out.hazard;
    assign o_deep_asleep   = w_res_out.deep;
    assign o_sleep_left    = w_res_out.sleep;
    assign o_spray_left    = w_res_out.spray;
    assign o_pause_left    = w_res_out.pause;

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the multi-zone valve timer
// Drives command words through the push/full queue and predicts the status
// word for each accepted command. Every popped status word is checked field
// by field against the oldest prediction. Covers directed corner cases, then
// random command streams under several idle and stall patterns, plus a
// long receiver hold that fills the block and stalls its input.
// ----------------------------------------------------------------------------

module tb_top;
    import mzvt_pkg::*;

    localparam int ZONES       = 3;
    localparam int CYCLE_LIMIT = 200000;
    // Mode 15 has no name in the package; the block must treat it as a no-op
    localparam logic [3:0] MODE_UNUSED = 4'd15;

    // ------------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------------
    logic              i_clk            = 1'b0;
    logic              i_rst_n          = 1'b0;
    logic              push             = 1'b0;
    logic              full;
    logic [3:0]        i_mode           = '0;
    logic [MASK_W-1:0] i_zone_mask      = '0;
    logic [7:0]        i_duration       = '0;
    logic              i_override_value = 1'b0;
    logic [1:0]        i_status_zone    = '0;
    logic              empty;
    logic              pop              = 1'b0;
    logic [MASK_W-1:0] o_zone_drive;
    logic [MASK_W-1:0] o_override_mask;
    logic              o_hazard_active;
    logic              o_deep_asleep;
    logic [7:0]        o_sleep_left;
    logic [7:0]        o_spray_left;
    logic [7:0]        o_pause_left;

    multi_zone_valve_timer #(
        .ZONES(ZONES)
    ) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .push            (push),
        .full            (full),
        .i_mode          (i_mode),
        .i_zone_mask     (i_zone_mask),
        .i_duration      (i_duration),
        .i_override_value(i_override_value),
        .i_status_zone   (i_status_zone),
        .empty           (empty),
        .pop             (pop),
        .o_zone_drive    (o_zone_drive),
        .o_override_mask (o_override_mask),
        .o_hazard_active (o_hazard_active),
        .o_deep_asleep   (o_deep_asleep),
        .o_sleep_left    (o_sleep_left),
        .o_spray_left    (o_spray_left),
        .o_pause_left    (o_pause_left)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    t_result pending_status[$];   // predicted status words, oldest first
    int      error_count    = 0;
    int      checked_count  = 0;
    int      cycle_count    = 0;
    int      send_idle_pct  = 0;  // chance per cycle that the sender holds off
    int      recv_stall_pct = 0;  // chance per cycle that the receiver stalls
    int      recv_hold      = 0;  // cycles left in a forced receiver hold-off

    // Predicted controller state
    logic [7:0]        zone_spray [ZONES];
    logic [7:0]        zone_pause [ZONES];
    logic              zone_ovr   [ZONES];
    logic [7:0]        sleep_timer;
    logic              deep_on;
    logic              hazard_on;
    logic [MASK_W-1:0] drive_now;

    // ------------------------------------------------------------------------
    // Controller prediction
    // ------------------------------------------------------------------------
    task automatic clear_controller();
        int z;
        for (z = 0; z < ZONES; z++) begin
            zone_spray[z] = '0;
            zone_pause[z] = '0;
            zone_ovr[z]   = 1'b0;
        end
        sleep_timer = '0;
        deep_on     = 1'b0;
        hazard_on   = 1'b0;
        drive_now   = '0;
    endtask

    // Apply one command to the predicted state and return its status word
    function automatic t_result advance_controller(logic [3:0] mode,
                                                   logic [MASK_W-1:0] mask,
                                                   logic [7:0] dur,
                                                   logic ovr,
                                                   logic [1:0] sz);
        t_result           r;
        logic              flip_to;
        logic [MASK_W-1:0] d;
        int                z;
        // Flip copies the inverse of zone 0's old bit into every selected zone
        flip_to = ~zone_ovr[0];
        case (mode)
            MODE_TICK: begin
                // Sleep counts down once per tick, before the zones
                if (sleep_timer != 0) sleep_timer = sleep_timer - 8'd1;
                d = '0;
                for (z = 0; z < ZONES; z++) begin
                    if (zone_pause[z] != 0) zone_pause[z] = zone_pause[z] - 8'd1;
                    if (zone_spray[z] != 0) zone_spray[z] = zone_spray[z] - 8'd1;
                    if (!hazard_on && (zone_ovr[z] ||
                        (zone_spray[z] != 0 && zone_pause[z] == 0 &&
                         sleep_timer == 0 && !deep_on)))
                        d[z] = 1'b1;
                end
                drive_now = d;
            end
            MODE_START, MODE_ADD, MODE_PAUSE, MODE_STOP,
            MODE_SET_OVR, MODE_FLIP_OVR: begin
                for (z = 0; z < ZONES; z++) begin
                    if (mask[z]) begin
                        case (mode)
                            MODE_START:   zone_spray[z] = dur;
                            MODE_ADD:     zone_spray[z] = zone_spray[z] + dur;
                            MODE_PAUSE:   zone_pause[z] = dur;
                            MODE_STOP:    zone_spray[z] = '0;
                            MODE_SET_OVR: zone_ovr[z]   = ovr;
                            default:      zone_ovr[z]   = flip_to;
                        endcase
                    end
                end
            end
            MODE_SLEEP:   sleep_timer = dur;
            MODE_DEEP:    deep_on = 1'b1;
            MODE_WAKE: begin
                sleep_timer = '0;
                deep_on     = 1'b0;
            end
            MODE_HZ_SET:  hazard_on = 1'b1;
            MODE_HZ_CLR:  hazard_on = 1'b0;
            MODE_HZ_FLIP: hazard_on = ~hazard_on;
            MODE_CLEAR: begin
                // Sleep and drive survive the clear command
                for (z = 0; z < ZONES; z++) begin
                    zone_spray[z] = '0;
                    zone_pause[z] = '0;
                    zone_ovr[z]   = 1'b0;
                end
                deep_on   = 1'b0;
                hazard_on = 1'b0;
            end
            default: ;
        endcase
        r.drive = drive_now;
        for (z = 0; z < MASK_W; z++) r.ovr_mask[z] = (z < ZONES) ? zone_ovr[z] : 1'b0;
        r.hazard = hazard_on;
        r.deep   = deep_on;
        r.sleep  = sleep_timer;
        if (sz < ZONES) begin
            r.spray = zone_spray[sz];
            r.pause = zone_pause[sz];
        end else begin
            r.spray = '0;
            r.pause = '0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------------
    task automatic report_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_error($sformatf("status word %0d: %s got %0h want %0h",
                                   checked_count, name, got, want));
    endtask

    // ------------------------------------------------------------------------
    // Sender: offer one command word, hold it until taken, then predict
    // ------------------------------------------------------------------------
    task automatic send_word(input logic [3:0] mode, input logic [MASK_W-1:0] mask,
                             input logic [7:0] dur, input logic ovr,
                             input logic [1:0] sz);
        // Drop push for a random number of cycles first
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push             <= 1'b1;
        i_mode           <= mode;
        i_zone_mask      <= mask;
        i_duration       <= dur;
        i_override_value <= ovr;
        i_status_zone    <= sz;
        // Hold the word until an edge sees push high with full low
        do @(posedge i_clk); while (full);
        pending_status.push_back(advance_controller(mode, mask, dur, ovr, sz));
    endtask

    // Mostly short durations so countdowns reach zero within a few ticks
    function automatic logic [7:0] pick_duration(int short_max);
        if ($urandom_range(3) == 0) return 8'($urandom_range(255));
        return 8'($urandom_range(short_max));
    endfunction

    // Random command stream, weighted toward ticks and zone commands
    task automatic send_random_words(input int n);
        int         k;
        int         pick;
        logic [3:0] mode;
        logic [7:0] dur;
        for (k = 0; k < n; k++) begin
            pick = $urandom_range(99);
            dur  = pick_duration(12);
            if      (pick < 35) mode = MODE_TICK;
            else if (pick < 45) mode = MODE_START;
            else if (pick < 52) mode = MODE_ADD;
            else if (pick < 58) mode = MODE_PAUSE;
            else if (pick < 62) mode = MODE_STOP;
            else if (pick < 68) mode = MODE_SET_OVR;
            else if (pick < 72) mode = MODE_FLIP_OVR;
            else if (pick < 76) mode = MODE_SLEEP;
            else if (pick < 78) mode = MODE_DEEP;
            else if (pick < 83) mode = MODE_WAKE;
            else if (pick < 85) mode = MODE_HZ_SET;
            else if (pick < 90) mode = MODE_HZ_CLR;
            else if (pick < 92) mode = MODE_HZ_FLIP;
            else if (pick < 94) mode = MODE_CLEAR;
            else if (pick < 97) mode = MODE_STATUS;
            else                mode = MODE_UNUSED;
            // Keep pauses and sleeps short so the spray path gets to drive
            if (mode == MODE_PAUSE || mode == MODE_SLEEP) dur = pick_duration(5);
            send_word(mode, MASK_W'($urandom_range(7)), dur,
                      1'($urandom_range(1)), 2'($urandom_range(3)));
        end
    endtask

    // Lower push and wait until every predicted status word has been popped
    task automatic wait_for_drain();
        push <= 1'b0;
        wait (pending_status.size() == 0);
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Status of an out-of-range zone straight after reset
        send_word(MODE_STATUS,   3'b000, 8'd0,   1'b0, 2'd3);
        send_word(MODE_START,    3'b111, 8'd255, 1'b0, 2'd0);
        send_word(MODE_TICK,     3'b000, 8'd0,   1'b0, 2'd1);
        // Add wraps past 255
        send_word(MODE_ADD,      3'b001, 8'd10,  1'b0, 2'd0);
        send_word(MODE_PAUSE,    3'b010, 8'd3,   1'b0, 2'd1);
        send_word(MODE_TICK,     3'b000, 8'd0,   1'b0, 2'd1);
        send_word(MODE_SET_OVR,  3'b100, 8'd0,   1'b1, 2'd2);
        // Flip takes zone 0's old bit, not each zone's own
        send_word(MODE_FLIP_OVR, 3'b011, 8'd0,   1'b0, 2'd0);
        send_word(MODE_FLIP_OVR, 3'b110, 8'd0,   1'b1, 2'd2);
        send_word(MODE_SLEEP,    3'b000, 8'd2,   1'b0, 2'd0);
        send_word(MODE_TICK,     3'b000, 8'd0,   1'b0, 2'd0);
        send_word(MODE_DEEP,     3'b000, 8'd0,   1'b0, 2'd1);
        send_word(MODE_TICK,     3'b000, 8'd0,   1'b0, 2'd2);
        send_word(MODE_WAKE,     3'b000, 8'd0,   1'b0, 2'd0);
        send_word(MODE_HZ_SET,   3'b000, 8'd0,   1'b0, 2'd0);
        send_word(MODE_TICK,     3'b000, 8'd0,   1'b0, 2'd1);
        send_word(MODE_HZ_FLIP,  3'b000, 8'd0,   1'b0, 2'd2);
        send_word(MODE_HZ_FLIP,  3'b000, 8'd0,   1'b0, 2'd0);
        send_word(MODE_HZ_CLR,   3'b000, 8'd0,   1'b0, 2'd1);
        send_word(MODE_STOP,     3'b111, 8'd0,   1'b0, 2'd0);
        // Tick with spray at zero leaves it at zero
        send_word(MODE_TICK,     3'b000, 8'd0,   1'b0, 2'd2);
        // Clear keeps the sleep count and the drive bits
        send_word(MODE_SLEEP,    3'b000, 8'd255, 1'b0, 2'd0);
        send_word(MODE_CLEAR,    3'b111, 8'd255, 1'b1, 2'd1);
        send_word(MODE_UNUSED,   3'b111, 8'd255, 1'b1, 2'd3);
        send_word(MODE_WAKE,     3'b000, 8'd0,   1'b0, 2'd0);
        wait_for_drain();
    endtask

    task automatic test_back_to_back();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_words(160);
        wait_for_drain();
    endtask

    task automatic test_sender_gaps();
        send_idle_pct  = 50;
        recv_stall_pct = 0;
        send_random_words(160);
        wait_for_drain();
    endtask

    task automatic test_receiver_stalls();
        send_idle_pct  = 0;
        recv_stall_pct = 50;
        send_random_words(160);
        wait_for_drain();
    endtask

    task automatic test_mixed_gaps();
        send_idle_pct  = 25;
        recv_stall_pct = 25;
        send_random_words(150);
        wait_for_drain();
    endtask

    // Hold the receiver off long enough to fill both queues and raise full
    task automatic test_full_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold      = 150;
        send_random_words(24);
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------------
    // Receiver: check each popped status word, then pick the next pop
    // ------------------------------------------------------------------------
    initial begin : status_checker
        t_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (pending_status.size() == 0) begin
                    report_error($sformatf("status word %0d popped with none predicted",
                                           checked_count));
                end else begin
                    want = pending_status.pop_front();
                    check_field("zone_drive",    8'(o_zone_drive),    8'(want.drive));
                    check_field("override_mask", 8'(o_override_mask), 8'(want.ovr_mask));
                    check_field("hazard_active", 8'(o_hazard_active), 8'(want.hazard));
                    check_field("deep_asleep",   8'(o_deep_asleep),   8'(want.deep));
                    check_field("sleep_left",    o_sleep_left,        want.sleep);
                    check_field("spray_left",    o_spray_left,        want.spray);
                    check_field("pause_left",    o_pause_left,        want.pause);
                end
                checked_count++;
            end
            // Hold pop low through reset and any forced hold-off
            if (!i_rst_n) begin
                pop <= 1'b0;
            end else if (recv_hold > 0) begin
                recv_hold--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if it overstays the cycle budget
    // ------------------------------------------------------------------------
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        clear_controller();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_back_to_back();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_gaps();
        test_full_stall();

        // Let any stray status word show up before the verdict
        repeat (10) @(posedge i_clk);
        if (pending_status.size() != 0)
            report_error($sformatf("%0d status words never arrived",
                                   pending_status.size()));
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
